### rtl/core/lr_pkg.sv
// ----------------------------------------------------------------------------
// lr_pkg
// Shared types and constants of the line rasterizer: coordinate widths,
// step codes, command kinds and the queue entry between front and back.
// ----------------------------------------------------------------------------
package lr_pkg;

    localparam int COORD_BITS    = 12;
    localparam int COLOUR_BITS   = 32;
    localparam int ERR_BITS      = COORD_BITS + 1;
    localparam int LEFT_BITS     = COORD_BITS + 1;

    // stream data widths, rounded up to whole bytes
    localparam int IN_DATA_BITS  = ((4 * COORD_BITS + COLOUR_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((2 * COORD_BITS + COLOUR_BITS + 7) / 8) * 8;

    localparam int Q_DEPTH       = 4;
    localparam int Q_PTR_BITS    = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS    = $clog2(Q_DEPTH + 1);

    typedef logic [COORD_BITS-1:0]  t_coord;
    typedef logic [COLOUR_BITS-1:0] t_colour;

    // two's complement step: -1, 0 or +1
    typedef logic [1:0] t_step;
    localparam t_step STEP_ZERO = 2'b00;
    localparam t_step STEP_POS  = 2'b01;
    localparam t_step STEP_NEG  = 2'b11;

    typedef enum logic {
        KIND_TICK  = 1'b0,
        KIND_START = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind   kind;
        t_coord  start_x;
        t_coord  start_y;
        t_coord  major_len;
        t_coord  minor_len;
        t_step   diag_sx;
        t_step   diag_sy;
        t_step   str_sx;
        t_step   str_sy;
        t_colour colour;
    } t_cmd;

    function automatic t_coord step_ext(input t_step s);
        return {{(COORD_BITS-2){s[1]}}, s};
    endfunction

endpackage

### rtl/core/lr_front.sv
// ----------------------------------------------------------------------------
// lr_front
// Input side: classifies each item as start or tick and, for a start, works
// out axis lengths, major/minor choice and step directions.
// ----------------------------------------------------------------------------
module lr_front
    import lr_pkg::*;
(
    input  logic                    i_rst_n,
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  logic [IN_DATA_BITS-1:0] i_s_axis_tdata,
    input  logic                    i_s_axis_tuser,
    input  logic                    i_q_full,
    output logic                    o_q_push,
    output t_cmd                    o_q_cmd
);

    t_coord x0, y0, x1, y1;
    t_coord w, h;
    t_step  sx, sy;
    logic   x_major;

    assign x0 = i_s_axis_tdata[COORD_BITS-1:0];
    assign y0 = i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign x1 = i_s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign y1 = i_s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];

    always_comb begin
        priority if (x1 > x0) begin
            sx = STEP_POS;
            w  = x1 - x0;
        end else if (x1 < x0) begin
            sx = STEP_NEG;
            w  = x0 - x1;
        end else begin
            sx = STEP_ZERO;
            w  = '0;
        end
        priority if (y1 > y0) begin
            sy = STEP_POS;
            h  = y1 - y0;
        end else if (y1 < y0) begin
            sy = STEP_NEG;
            h  = y0 - y1;
        end else begin
            sy = STEP_ZERO;
            h  = '0;
        end
    end

    // equal lengths take y as major
    assign x_major = (w > h);

    always_comb begin
        o_q_cmd.kind      = t_kind'(i_s_axis_tuser);
        o_q_cmd.start_x   = x0;
        o_q_cmd.start_y   = y0;
        o_q_cmd.major_len = x_major ? w : h;
        o_q_cmd.minor_len = x_major ? h : w;
        o_q_cmd.diag_sx   = sx;
        o_q_cmd.diag_sy   = sy;
        o_q_cmd.str_sx    = x_major ? sx : STEP_ZERO;
        o_q_cmd.str_sy    = x_major ? STEP_ZERO : sy;
        o_q_cmd.colour    = i_s_axis_tdata[4*COORD_BITS+COLOUR_BITS-1:4*COORD_BITS];
    end

    assign o_s_axis_tready = i_rst_n && !i_q_full;
    assign o_q_push        = i_s_axis_tvalid && o_s_axis_tready;

endmodule

### rtl/core/lr_fifo.sv
// ----------------------------------------------------------------------------
// lr_fifo
// Short command queue between front and back, so either side can stall
// without holding up the other.
// ----------------------------------------------------------------------------
module lr_fifo
    import lr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd                  r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_BITS-1:0] r_count, n_count;

    assign o_full  = (r_count == Q_CNT_BITS'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### rtl/core/lr_back.sv
// ----------------------------------------------------------------------------
// lr_back
// Line stepper: loads a new line on a start command and, on each tick while a
// line is active, emits the cursor pixel into the output register and takes one step.
// ----------------------------------------------------------------------------
module lr_back
    import lr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_empty,
    input  t_cmd                     i_q_cmd,
    output logic                     o_q_pop,
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] o_m_axis_tdata,
    output logic                     o_m_axis_tlast
);

    logic                 r_active, n_active;
    t_coord               r_cur_x, n_cur_x;
    t_coord               r_cur_y, n_cur_y;
    logic [ERR_BITS-1:0]  r_err, n_err;
    t_coord               r_major, r_minor;
    t_step                r_dsx, r_dsy, r_ssx, r_ssy;
    logic [LEFT_BITS-1:0] r_left, n_left;
    t_colour              r_colour;

    logic                 r_out_valid, n_out_valid;
    t_coord               r_out_x, r_out_y;
    t_colour              r_out_colour;
    logic                 r_out_last;

    logic                 out_free;
    logic                 do_start, do_pixel;
    logic                 is_last;
    logic [ERR_BITS-1:0]  err_sum;
    logic                 take_diag;

    assign out_free = !r_out_valid || i_m_axis_tready;
    assign o_q_pop  = !i_q_empty && out_free;
    assign do_start = o_q_pop && (i_q_cmd.kind == KIND_START);
    assign do_pixel = o_q_pop && (i_q_cmd.kind == KIND_TICK) && r_active;
    assign is_last  = (r_left <= LEFT_BITS'(1));

    assign err_sum   = r_err + {1'b0, r_minor};
    assign take_diag = (err_sum >= {1'b0, r_major});

    always_comb begin
        n_active = r_active;
        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_err    = r_err;
        n_left   = r_left;
        if (do_start) begin
            n_active = 1'b1;
            n_cur_x  = i_q_cmd.start_x;
            n_cur_y  = i_q_cmd.start_y;
            n_err    = {1'b0, i_q_cmd.major_len >> 1};
            n_left   = {1'b0, i_q_cmd.major_len} + LEFT_BITS'(1);
        end else if (do_pixel) begin
            if (take_diag) begin
                n_err   = err_sum - {1'b0, r_major};
                n_cur_x = r_cur_x + step_ext(r_dsx);
                n_cur_y = r_cur_y + step_ext(r_dsy);
            end else begin
                n_err   = err_sum;
                n_cur_x = r_cur_x + step_ext(r_ssx);
                n_cur_y = r_cur_y + step_ext(r_ssy);
            end
            if (is_last) begin
                n_left   = '0;
                n_active = 1'b0;
            end else begin
                n_left   = r_left - 1'b1;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (do_pixel) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_x <= n_cur_x;
        r_cur_y <= n_cur_y;
        r_err   <= n_err;
        r_left  <= n_left;
        if (do_start) begin
            r_major  <= i_q_cmd.major_len;
            r_minor  <= i_q_cmd.minor_len;
            r_dsx    <= i_q_cmd.diag_sx;
            r_dsy    <= i_q_cmd.diag_sy;
            r_ssx    <= i_q_cmd.str_sx;
            r_ssy    <= i_q_cmd.str_sy;
            r_colour <= i_q_cmd.colour;
        end
        if (do_pixel) begin
            r_out_x      <= r_cur_x;
            r_out_y      <= r_cur_y;
            r_out_colour <= r_colour;
            r_out_last   <= is_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_DATA_BITS'({r_out_colour, r_out_y, r_out_x});
    assign o_m_axis_tlast  = r_out_last;

endmodule

### rtl/core/line_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// line_rasterizer_unit
// Bresenham line rasterizer for all octants: a start item loads a line, each tick
// item up to the line's end gives the next pixel with its colour, the end pixel flagged.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                          | side band
//  --------+-----+---------------------------------------------+------------------
//  s_axis  | in  | start_x, start_y, end_x, end_y, line_colour | tuser: opcode
//  m_axis  | out | pixel_x, pixel_y, pixel_colour              | tlast: last_pixel
//
//  one item per cycle in while the queue has room, one pixel per cycle out while
//  tready is high; a tick's pixel passes the queue, then the stepper output register
//  the four-entry command queue lets input keep flowing while output stalls
//  reset clears the queue, the line active flag and the output register
// ----------------------------------------------------------------------------
module line_rasterizer_unit
    import lr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // start_x, start_y, end_x, end_y, line_colour, zero pad
    input  logic [IN_DATA_BITS-1:0]  i_s_axis_tdata,
    // opcode: 0 tick, 1 start
    input  logic                     i_s_axis_tuser,
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    // pixel_x, pixel_y, pixel_colour, zero pad
    output logic [OUT_DATA_BITS-1:0] o_m_axis_tdata,
    // last_pixel
    output logic                     o_m_axis_tlast
);

    logic q_push, q_pop, q_full, q_empty;
    t_cmd q_wr_cmd, q_rd_cmd;

    lr_front u_front (
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_q_cmd         (q_wr_cmd)
    );

    lr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_wr_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_rd_cmd)
    );

    lr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_q_cmd         (q_rd_cmd),
        .o_q_pop         (q_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

### rtl/core/lr_checker.sv
// ----------------------------------------------------------------------------
// lr_checker
// Port-level checks on the line rasterizer, attached to the top by bind.
// ----------------------------------------------------------------------------
module lr_checker
    import lr_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_s_axis_tvalid,
    input logic                     o_s_axis_tready,
    input logic [IN_DATA_BITS-1:0]  i_s_axis_tdata,
    input logic                     i_s_axis_tuser,
    input logic                     o_m_axis_tvalid,
    input logic                     i_m_axis_tready,
    input logic [OUT_DATA_BITS-1:0] o_m_axis_tdata,
    input logic                     o_m_axis_tlast
);

    // reset empties the output register
    a_rst_out_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // reset empties the command queue, so input is taken right away
    a_rst_in_ready: assert property (@(posedge i_clk)
        !i_rst_n ##1 i_rst_n |-> o_s_axis_tready)
        else $error("input not ready after reset");

    // a stalled pixel holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled pixel changed");

    // an offered input carries known kind and payload
    a_in_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid |-> !$isunknown({i_s_axis_tuser, i_s_axis_tdata}))
        else $error("unknown bits on offered input");

endmodule

bind line_rasterizer_unit lr_checker u_lr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

### sim/line_rasterizer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_rasterizer_checker
// Watches both stream channels of the line rasterizer. Every accepted input
// transfer runs through a local line stepper that holds its own copy of the
// line state; the pixels it yields are queued and each output transfer is
// compared field by field with the oldest queued pixel.
// ----------------------------------------------------------------------------
module line_rasterizer_checker
    import lr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    input  logic                     i_s_tready,
    // start_x, start_y, end_x, end_y, line_colour, zero pad
    input  logic [IN_DATA_BITS-1:0]  i_s_tdata,
    // opcode
    input  logic                     i_s_tuser,
    input  logic                     i_m_tvalid,
    input  logic                     i_m_tready,
    // pixel_x, pixel_y, pixel_colour, zero pad
    input  logic [OUT_DATA_BITS-1:0] i_m_tdata,
    // last_pixel
    input  logic                     i_m_tlast,
    output int                       o_fail_count,
    output int                       o_pending
);

    typedef struct {
        t_coord  x;
        t_coord  y;
        t_colour colour;
        logic    last;
    } t_pixel;

    t_pixel pixel_queue[$];

    // line stepper state
    logic                ln_active;
    t_coord              cur_x, cur_y;
    logic [ERR_BITS-1:0] err_acc;
    t_coord              major_len, minor_len;
    t_step               diag_dx, diag_dy, str_dx, str_dy;
    logic [LEFT_BITS-1:0] pix_left;
    t_colour             ln_colour;

    function automatic t_step axis_step(input t_coord a, input t_coord b);
        if (b > a) return STEP_POS;
        if (b < a) return STEP_NEG;
        return STEP_ZERO;
    endfunction

    function automatic t_coord axis_len(input t_coord a, input t_coord b);
        return (a > b) ? a - b : b - a;
    endfunction

    // step codes are two's complement, so a signed widen gives the addend
    function automatic t_coord moved(input t_coord c, input t_step s);
        return c + t_coord'($signed(s));
    endfunction

    task automatic load_line(input logic [IN_DATA_BITS-1:0] d);
        t_coord x0, y0, x1, y1, w, h;
        x0 = d[11:0];
        y0 = d[23:12];
        x1 = d[35:24];
        y1 = d[47:36];
        w  = axis_len(x0, x1);
        h  = axis_len(y0, y1);
        diag_dx = axis_step(x0, x1);
        diag_dy = axis_step(y0, y1);
        // ties go to y as the major axis
        if (w > h) begin
            major_len = w;
            minor_len = h;
            str_dx    = diag_dx;
            str_dy    = STEP_ZERO;
        end else begin
            major_len = h;
            minor_len = w;
            str_dx    = STEP_ZERO;
            str_dy    = diag_dy;
        end
        err_acc   = ERR_BITS'(major_len >> 1);
        pix_left  = LEFT_BITS'(major_len) + 1'b1;
        cur_x     = x0;
        cur_y     = y0;
        ln_colour = d[79:48];
        ln_active = 1'b1;
    endtask

    task automatic step_line();
        t_pixel p;
        if (!ln_active) return;
        p.x      = cur_x;
        p.y      = cur_y;
        p.colour = ln_colour;
        p.last   = (pix_left <= 1);
        pixel_queue.push_back(p);
        err_acc = err_acc + ERR_BITS'(minor_len);
        if (err_acc >= ERR_BITS'(major_len)) begin
            err_acc = err_acc - ERR_BITS'(major_len);
            cur_x   = moved(cur_x, diag_dx);
            cur_y   = moved(cur_y, diag_dy);
        end else begin
            cur_x   = moved(cur_x, str_dx);
            cur_y   = moved(cur_y, str_dy);
        end
        if (pix_left <= 1) begin
            pix_left  = '0;
            ln_active = 1'b0;
        end else begin
            pix_left  = pix_left - 1'b1;
        end
    endtask

    task automatic note_failure();
        o_fail_count = o_fail_count + 1;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_pixel exp_px;
        t_coord got_x, got_y;
        t_colour got_c;
        if (!i_rst_n) begin
            ln_active = 1'b0;
            cur_x     = '0;
            cur_y     = '0;
            err_acc   = '0;
            major_len = '0;
            minor_len = '0;
            diag_dx   = STEP_ZERO;
            diag_dy   = STEP_ZERO;
            str_dx    = STEP_ZERO;
            str_dy    = STEP_ZERO;
            pix_left  = '0;
            ln_colour = '0;
            pixel_queue.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                if (t_kind'(i_s_tuser) == KIND_START)
                    load_line(i_s_tdata);
                else
                    step_line();
            end
            if (i_m_tvalid && i_m_tready) begin
                got_x = i_m_tdata[11:0];
                got_y = i_m_tdata[23:12];
                got_c = i_m_tdata[55:24];
                if (pixel_queue.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: unexpected pixel x=%0d y=%0d colour=%h last=%0b",
                                 $realtime, got_x, got_y, got_c, i_m_tlast);
                    note_failure();
                end else begin
                    exp_px = pixel_queue.pop_front();
                    if (got_x !== exp_px.x || got_y !== exp_px.y ||
                        got_c !== exp_px.colour || i_m_tlast !== exp_px.last) begin
                        if (o_fail_count < 10)
                            $display("%0t: pixel mismatch, expected x=%0d y=%0d colour=%h last=%0b, got x=%0d y=%0d colour=%h last=%0b",
                                     $realtime, exp_px.x, exp_px.y, exp_px.colour,
                                     exp_px.last, got_x, got_y, got_c, i_m_tlast);
                        note_failure();
                    end
                end
            end
        end
        o_pending = pixel_queue.size();
    end

endmodule

### sim/tb_line_rasterizer_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_line_rasterizer_unit
// Drives start and tick transfers into the line rasterizer: a few hand-picked
// lines (single point, equal axes, a straight run, restart mid-line) and then
// random lines of mostly short length in all octants, under two patterns
// of random idling on both channels and one with none, plus one long output
// stall. The checker beside the block predicts and compares every pixel.
// ----------------------------------------------------------------------------
module tb_line_rasterizer_unit;
    import lr_pkg::*;

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata;
    logic                     s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic                     m_tlast;

    int fail_count;
    int pending;
    int src_idle_pct;
    int snk_idle_pct;
    int hold_left;
    int items_sent;

    line_rasterizer_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    line_rasterizer_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // pixel receiver: random backpressure, or a counted hold-off when asked
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                m_tready  <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
        end
    end

    task automatic send_item(input t_kind kind, input logic [IN_DATA_BITS-1:0] data);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= kind;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_tick();
        // payload of a tick is ignored, so fill it with noise
        send_item(KIND_TICK, {16'($urandom()), 32'($urandom()), 32'($urandom())});
    endtask

    task automatic draw_line(input t_coord x0, input t_coord y0, input t_coord x1,
                             input t_coord y1, input t_colour col, input int n_ticks);
        int dx, dy, mj;
        dx = (x0 > x1) ? x0 - x1 : x1 - x0;
        dy = (y0 > y1) ? y0 - y1 : y1 - y0;
        mj = (dx > dy) ? dx : dy;
        send_item(KIND_START, {col, y1, x1, y0, x0});
        for (int i = 0; i < n_ticks; i++)
            send_tick();
        items_sent = items_sent + 1 + ((n_ticks < mj + 1) ? n_ticks : mj + 1);
    endtask

    function automatic t_coord near_coord(input t_coord c, input int span);
        int lo, hi;
        lo = (c > span) ? c - span : 0;
        hi = (c + span > 4095) ? 4095 : c + span;
        return t_coord'($urandom_range(hi, lo));
    endfunction

    task automatic random_lines(input int n_items);
        int stop_at, span, mj, n_ticks, pick;
        t_coord x0, y0, x1, y1;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            span = (pick < 70) ? 12 : (pick < 95) ? 64 : 400;
            x0 = t_coord'($urandom_range(0, 4095));
            y0 = t_coord'($urandom_range(0, 4095));
            x1 = near_coord(x0, span);
            y1 = near_coord(y0, span);
            if ($urandom_range(0, 9) == 0)
                y1 = y0 + x1 - x0;  // forces equal axis lengths where it lands in range
            mj = (x0 > x1) ? x0 - x1 : x1 - x0;
            if (((y0 > y1) ? y0 - y1 : y1 - y0) > mj)
                mj = (y0 > y1) ? y0 - y1 : y1 - y0;
            pick = $urandom_range(0, 99);
            if (pick < 75)
                n_ticks = mj + 1 + $urandom_range(0, 2);
            else if (pick < 92)
                n_ticks = $urandom_range(0, mj);     // cut short by the next start
            else
                n_ticks = 0;
            draw_line(x0, y0, x1, y1, t_colour'($urandom()), n_ticks);
        end
    endtask

    initial begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = KIND_TICK;
        src_idle_pct = 37;
        snk_idle_pct = 46;
        hold_left    = 0;
        items_sent   = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ticks with no line loaded give nothing
        send_tick();
        send_tick();
        // single point, then one tick past its end
        draw_line(12'd4095, 12'd0, 12'd4095, 12'd0, 32'hFFFF_FFFF, 2);
        // equal axis lengths, y major
        draw_line(12'd10, 12'd10, 12'd13, 12'd7, 32'h0000_0000, 4);
        // horizontal run along the top coordinate
        draw_line(12'd0, 12'd4095, 12'd3, 12'd4095, 32'hA5A5_A5A5, 4);
        // longest line, dropped by a restart
        draw_line(12'd4095, 12'd4095, 12'd0, 12'd0, 32'h5A5A_5A5A, 3);
        draw_line(12'd2, 12'd1, 12'd0, 12'd6, 32'h1234_5678, 6);

        random_lines(225);

        src_idle_pct = 46;
        snk_idle_pct = 37;
        random_lines(225);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        // long output stall while ticks keep coming
        @(posedge clk);
        hold_left = 120;
        @(negedge clk);
        draw_line(12'd100, 12'd200, 12'd160, 12'd180, 32'hC0FF_EE00, 61);
        random_lines(225);

        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### line_rasterizer_unit.f
rtl/core/lr_pkg.sv
rtl/core/lr_front.sv
rtl/core/lr_fifo.sv
rtl/core/lr_back.sv
rtl/core/line_rasterizer_unit.sv
rtl/core/lr_checker.sv
sim/line_rasterizer_checker.sv
sim/tb_line_rasterizer_unit.sv
